// ===== rtl/core/pcd_pkg.sv =====
`default_nettype none
package pcd_pkg;

    localparam int INDEX_BITS_DEFAULT = 10;
    localparam int NUM_TILES          = 16;
    localparam int NUM_PARTS          = 16;
    localparam int BLOCK_INDEX_W      = 10;
    localparam int TILE_W             = 4;
    localparam int PART_W             = 4;
    localparam int CFG_INDEX_W        = 1;
    localparam int CFG_DATA_W         = 3;

    localparam logic [1:0] OP_READ      = 2'd0;
    localparam logic [1:0] OP_READ_EXCL = 2'd1;
    localparam logic [1:0] OP_UPGRADE   = 2'd2;

    localparam logic [1:0] ST_I  = 2'd0;
    localparam logic [1:0] ST_S  = 2'd1;
    localparam logic [1:0] ST_EM = 2'd2;

    localparam logic [1:0] SRC_NONE   = 2'd0;
    localparam logic [1:0] SRC_MEMORY = 2'd1;
    localparam logic [1:0] SRC_REMOTE = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_TPP_LOG2 = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FORWARD  = 1'd1;

    localparam logic [2:0] SCHEME_TILE    = 3'd0;
    localparam logic [2:0] SCHEME_PAIR    = 3'd1;
    localparam logic [2:0] SCHEME_QUAD    = 3'd2;
    localparam logic [2:0] SCHEME_HALF    = 3'd3;

    localparam logic [NUM_TILES-1:0] QUAD_MASKS [4] = '{
        16'b0000000000110011,
        16'b0000000011001100,
        16'b0011001100000000,
        16'b1100110000000000
    };
    localparam logic [NUM_TILES-1:0] HALF_MASK_P0 = 16'b1111111100000000;
    localparam logic [NUM_TILES-1:0] HALF_MASK_P1 = 16'b0000000011111111;
    localparam logic [NUM_TILES-1:0] ALL_TILES    = 16'b1111111111111111;

    typedef struct packed {
        logic [1:0]               op;
        logic [BLOCK_INDEX_W-1:0] block_index;
        logic [TILE_W-1:0]        requester_tile;
    } t_req;

    typedef struct packed {
        logic [1:0]           new_state;
        logic [NUM_PARTS-1:0] invalidate_mask;
        logic [NUM_PARTS-1:0] intervene_mask;
        logic [1:0]           data_source;
        logic                 request_error;
        logic [PART_W-1:0]    requester_partition;
    } t_rsp;

    typedef struct packed {
        logic [1:0]           state;
        logic [NUM_PARTS-1:0] sharers;
    } t_entry;

    function automatic logic [PART_W-1:0] pcd_tile_partition(
        input logic [2:0]        scheme,
        input logic [TILE_W-1:0] tile
    );
        logic [PART_W-1:0] part;
        part = '0;
        case (scheme)
            SCHEME_TILE: part = tile;
            SCHEME_PAIR: part = {1'b0, tile[TILE_W-1:1]};
            SCHEME_QUAD: begin
                for (int k = 0; k < 4; k++) begin
                    if (QUAD_MASKS[k][tile]) begin
                        part = PART_W'(k);
                    end
                end
            end
            SCHEME_HALF: begin
                if (HALF_MASK_P1[tile]) begin
                    part = PART_W'(1);
                end else if (HALF_MASK_P0[tile]) begin
                    part = '0;
                end
            end
            default: part = (ALL_TILES[tile]) ? '0 : '0;
        endcase
        return part;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/partition_directory_coherence.sv =====
`default_nettype none
// Coherence directory that serves one request per clock cycle while o_busy is low. A request is
// taken when i_start is high and o_busy is low. Its result is driven on o_result with the o_done
// strobe for a single cycle, after the r_s1 stage and the r_out register, and cannot be held off
// by the receiver. Each request reads its entry from the directory memory at the transfer edge
// and writes it back at the next edge, and a request to the same block in the following cycle is
// served from the write-back path, so back-to-back requests to any blocks run at one per cycle.
// After reset the block clears its directory memory one entry per cycle, all 2**INDEX_BITS entries
// (1024 by default), holding o_busy high until done; configuration writes are taken throughout.
module partition_directory_coherence #(
    parameter int INDEX_BITS = pcd_pkg::INDEX_BITS_DEFAULT
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_start,
    output logic                                  o_busy,
    input  wire  pcd_pkg::t_req                   i_req,
    output logic                                  o_done,
    output pcd_pkg::t_rsp                         o_result,
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire  [pcd_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  wire  [pcd_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import pcd_pkg::*;

    localparam int DEPTH = 1 << INDEX_BITS;

    t_entry r_dir_mem [DEPTH];

    logic                  r_clearing;
    logic [INDEX_BITS-1:0] r_clr_addr;
    logic [2:0]            r_tpp_log2;
    logic                  r_fwd_en;

    logic                  r_s1_valid;
    t_req                  r_s1_req;
    logic [INDEX_BITS-1:0] r_s1_addr;
    t_entry                r_rd_data;
    logic                  r_fwd_hit;
    t_entry                r_fwd_data;

    logic                  r_out_valid;
    t_rsp                  r_out;

    logic                  w_accept;
    logic [INDEX_BITS-1:0] w_addr;
    t_entry                w_cur;
    logic [PART_W-1:0]     w_part;
    logic [NUM_PARTS-1:0]  w_pbit;
    logic [NUM_PARTS-1:0]  w_others;
    logic [1:0]            w_src_any;
    t_entry                n_entry;
    t_rsp                  n_rsp;
    logic                  w_we;
    logic [INDEX_BITS-1:0] w_wa;
    t_entry                w_wd;

    generate
        if (INDEX_BITS <= BLOCK_INDEX_W) begin : g_addr_narrow
            assign w_addr = i_req.block_index[INDEX_BITS-1:0];
        end else begin : g_addr_wide
            assign w_addr = {{(INDEX_BITS - BLOCK_INDEX_W){1'b0}}, i_req.block_index};
        end
    endgenerate

    assign w_accept    = i_start && !r_clearing;
    assign o_busy      = r_clearing;
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_out_valid;
    assign o_result    = r_out;

    always_comb begin
        w_cur     = r_fwd_hit ? r_fwd_data : r_rd_data;
        w_part    = pcd_tile_partition(r_tpp_log2, r_s1_req.requester_tile);
        w_pbit    = NUM_PARTS'(1) << w_part;
        w_others  = w_cur.sharers & ~w_pbit;
        w_src_any = (r_fwd_en && (w_others != '0)) ? SRC_REMOTE : SRC_MEMORY;

        n_entry                   = w_cur;
        n_rsp.invalidate_mask     = '0;
        n_rsp.intervene_mask      = '0;
        n_rsp.data_source         = SRC_NONE;
        n_rsp.request_error       = 1'b0;
        n_rsp.requester_partition = w_part;

        case (r_s1_req.op)
            OP_READ: begin
                if (w_cur.state == ST_I) begin
                    n_rsp.data_source = SRC_MEMORY;
                    n_entry.sharers   = w_pbit;
                    n_entry.state     = ST_EM;
                end else if (w_cur.state == ST_S) begin
                    n_rsp.data_source = w_src_any;
                    n_entry.sharers   = w_cur.sharers | w_pbit;
                end else begin
                    n_rsp.intervene_mask = w_cur.sharers;
                    n_rsp.data_source    = w_src_any;
                    n_entry.sharers      = w_cur.sharers | w_pbit;
                    n_entry.state        = ST_S;
                end
            end
            OP_READ_EXCL: begin
                if (w_cur.state == ST_I) begin
                    n_rsp.data_source = SRC_MEMORY;
                end else begin
                    n_rsp.invalidate_mask = w_others;
                    n_rsp.data_source     = w_src_any;
                end
                n_entry.sharers = w_pbit;
                n_entry.state   = ST_EM;
            end
            OP_UPGRADE: begin
                if (w_cur.state == ST_S) begin
                    n_rsp.invalidate_mask = w_others;
                    n_entry.sharers       = w_pbit;
                    n_entry.state         = ST_EM;
                end else begin
                    n_rsp.request_error = 1'b1;
                end
            end
            default: n_rsp.request_error = 1'b1;
        endcase

        n_rsp.new_state = n_entry.state;
    end

    always_comb begin
        if (r_clearing) begin
            w_we = 1'b1;
            w_wa = r_clr_addr;
            w_wd = '0;
        end else begin
            w_we = r_s1_valid;
            w_wa = r_s1_addr;
            w_wd = n_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_dir_mem[w_wa] <= w_wd;
        end
        r_rd_data <= r_dir_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_tpp_log2  <= '0;
            r_fwd_en    <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + INDEX_BITS'(1);
                if (&r_clr_addr) begin
                    r_clearing <= 1'b0;
                end
            end
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_TPP_LOG2) begin
                    r_tpp_log2 <= i_cfg_data;
                end else if (i_cfg_index == CFG_FORWARD) begin
                    r_fwd_en <= i_cfg_data[0];
                end
            end
            r_s1_valid  <= w_accept;
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_req   <= i_req;
            r_s1_addr  <= w_addr;
            r_fwd_hit  <= r_s1_valid && (r_s1_addr == w_addr);
            r_fwd_data <= n_entry;
        end
        if (r_s1_valid) begin
            r_out <= n_rsp;
        end
    end

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##2 o_done)
        else $error("accepted request produced no result");

    a_error_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.request_error) |->
            (o_result.invalidate_mask == '0 && o_result.intervene_mask == '0 &&
             o_result.data_source == SRC_NONE))
        else $error("faulty request carried a coherence action");

    a_em_single_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && n_entry.state == ST_EM) |-> $onehot(n_entry.sharers))
        else $error("exclusive entry without exactly one owner partition");

    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> (!r_s1_valid && !r_out_valid))
        else $error("request in flight while the directory is cleared");

endmodule
`default_nettype wire
